@@ rtl/core/sed_pkg.sv @@
// ----------------------------------------------------------------------------
// sed_pkg
// Shared types and constants of the software event dispatcher.
// ----------------------------------------------------------------------------
package sed_pkg;

  localparam int unsigned EVENT_SLOTS = 8;
  localparam int unsigned HART_COUNT  = 8;
  localparam int unsigned SLOT_W      = $clog2(EVENT_SLOTS);

  localparam logic [1:0] LC_UNUSED     = 2'd0;
  localparam logic [1:0] LC_REGISTERED = 2'd1;
  localparam logic [1:0] LC_ENABLED    = 2'd2;
  localparam logic [1:0] LC_RUNNING    = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_STATE = 2'd1;
  localparam logic [1:0] ST_PARAM = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam logic [3:0] REQ_REGISTER   = 4'd0;
  localparam logic [3:0] REQ_UNREGISTER = 4'd1;
  localparam logic [3:0] REQ_ENABLE     = 4'd2;
  localparam logic [3:0] REQ_DISABLE    = 4'd3;
  localparam logic [3:0] REQ_INJECT     = 4'd4;
  localparam logic [3:0] REQ_COMPLETE   = 4'd5;
  localparam logic [3:0] REQ_WRITE_ATTR = 4'd6;
  localparam logic [3:0] REQ_READ_ATTR  = 4'd7;
  localparam logic [3:0] REQ_REMOTE     = 4'd8;

  localparam logic [3:0] ATTR_STATUS = 4'd0;
  localparam logic [3:0] ATTR_PRIO   = 4'd1;
  localparam logic [3:0] ATTR_CONFIG = 4'd2;
  localparam logic [3:0] ATTR_HART   = 4'd3;
  localparam logic [3:0] ATTR_PC     = 4'd4;
  localparam logic [3:0] ATTR_ARG    = 4'd5;

  localparam logic [1:0] CFG_LOCAL_HART = 2'd0;
  localparam logic [1:0] CFG_STARTED    = 2'd1;
  localparam logic [1:0] CFG_GLOBAL     = 2'd2;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [2:0]  event_index;
    logic [2:0]  target_hart;
    logic [3:0]  attr_index;
    logic [63:0] write_value;
    logic [63:0] second_value;
    logic        known;
  } req_t;

  typedef struct packed {
    logic [1:0]  status_code;
    logic        run_valid;
    logic [2:0]  run_event;
    logic [63:0] run_entry_pc;
    logic [63:0] run_entry_arg;
    logic        resume;
    logic        kick_valid;
    logic [2:0]  kick_hart;
    logic [63:0] read_value;
  } rsp_t;

endpackage

@@ rtl/core/sed_front.sv @@
// ----------------------------------------------------------------------------
// sed_front
// Accepts request beats, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module sed_front import sed_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  output logic        s_ready_o,
  input  logic [3:0]  req_type_i,
  input  logic [2:0]  event_index_i,
  input  logic [2:0]  target_hart_i,
  input  logic [3:0]  attr_index_i,
  input  logic [63:0] write_value_i,
  input  logic [63:0] second_value_i,
  output logic        q_valid_o,
  input  logic        q_pop_i,
  output req_t        q_req_o
);
  req_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push;
  req_t       nreq;

  assign s_ready_o = (cnt_q != 2'd2);
  assign push      = s_valid_i && s_ready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_req_o   = mem_q[rp_q];

  always_comb begin
    nreq.req_type     = req_type_i;
    nreq.event_index  = event_index_i;
    nreq.target_hart  = target_hart_i;
    nreq.attr_index   = attr_index_i;
    nreq.write_value  = write_value_i;
    nreq.second_value = second_value_i;
    nreq.known        = ({1'b0, event_index_i} < 4'(EVENT_SLOTS)) &&
                        (req_type_i <= REQ_REMOTE);
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= nreq;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end
endmodule

@@ rtl/core/sed_back.sv @@
// ----------------------------------------------------------------------------
// sed_back
// Executes requests on the event table; dispatch scans one slot a cycle.
// ----------------------------------------------------------------------------
module sed_back import sed_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        q_valid_i,
  output logic        q_pop_o,
  input  req_t        q_req_i,
  output logic        m_valid_o,
  input  logic        m_ready_i,
  output rsp_t        m_rsp_o
);
  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_OUT} state_e;

  state_e      state_q;
  logic [2:0]  local_q;
  logic [7:0]  started_q, global_q;
  logic [1:0]  lc_q   [EVENT_SLOTS];
  logic        pend_q [EVENT_SLOTS];
  logic        one_q  [EVENT_SLOTS];
  logic [31:0] prio_q [EVENT_SLOTS];
  logic [2:0]  hart_q [EVENT_SLOTS];
  logic [63:0] pc_mem [EVENT_SLOTS];
  logic [63:0] arg_mem [EVENT_SLOTS];
  logic [SLOT_W:0]   scan_q;
  logic              best_v_q;
  logic [SLOT_W-1:0] best_q;
  logic              resume_on_q;
  rsp_t              rsp_q;

  logic [SLOT_W-1:0] s, sc;
  logic [1:0]  lc;
  logic        glob, home, cand, better;
  logic [2:0]  hof, inj_h;
  logic [31:0] wh;

  assign s     = q_req_i.event_index[SLOT_W-1:0];
  assign lc    = lc_q[s];
  assign glob  = global_q[q_req_i.event_index];
  assign hof   = glob ? hart_q[s] : local_q;
  assign inj_h = glob ? hart_q[s] : q_req_i.target_hart;
  assign wh    = q_req_i.write_value[31:0];
  assign sc    = scan_q[SLOT_W-1:0];
  assign home  = (global_q[3'(sc)] ? hart_q[sc] : local_q) == local_q;
  assign cand  = lc_q[sc][1] && home && (lc_q[sc] == LC_RUNNING || pend_q[sc]);
  assign better = !best_v_q || prio_q[sc] < prio_q[best_q];

  assign q_pop_o   = (state_q == S_IDLE) && q_valid_i;
  assign m_valid_o = (state_q == S_OUT);
  assign m_rsp_o   = rsp_q;

  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_req_i.known && q_req_i.req_type == REQ_REGISTER && lc == LC_UNUSED) begin
      pc_mem[s]  <= q_req_i.write_value;
      arg_mem[s] <= q_req_i.second_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      local_q <= 3'd0; started_q <= 8'd1; global_q <= 8'd18;
      for (int i = 0; i < EVENT_SLOTS; i++) begin
        lc_q[i] <= LC_UNUSED; pend_q[i] <= 1'b0; one_q[i] <= 1'b0;
        prio_q[i] <= '0; hart_q[i] <= 3'd0;
      end
      scan_q <= '0; best_v_q <= 1'b0; best_q <= '0; resume_on_q <= 1'b0;
      rsp_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LOCAL_HART: local_q <= cfg_data_i[2:0];
          CFG_STARTED:    started_q <= cfg_data_i;
          CFG_GLOBAL:     global_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: if (q_pop_o) begin
          logic go;
          logic res_on;
          rsp_t nr;
          go = 1'b0;
          res_on = 1'b0;
          nr = '0;
          if (!q_req_i.known) nr.status_code = ST_PARAM;
          else case (q_req_i.req_type)
            REQ_REGISTER:
              if (lc != LC_UNUSED) nr.status_code = ST_STATE;
              else lc_q[s] <= LC_REGISTERED;
            REQ_UNREGISTER:
              if (lc != LC_REGISTERED) nr.status_code = ST_STATE;
              else lc_q[s] <= LC_UNUSED;
            REQ_ENABLE:
              if (lc != LC_REGISTERED) nr.status_code = ST_STATE;
              else begin
                lc_q[s] <= LC_ENABLED;
                if (pend_q[s]) begin
                  if (hof == local_q) go = 1'b1;
                  else begin nr.kick_valid = 1'b1; nr.kick_hart = hof; end
                end
              end
            REQ_DISABLE:
              if (lc != LC_ENABLED) nr.status_code = ST_STATE;
              else lc_q[s] <= LC_REGISTERED;
            REQ_INJECT:
              if (inj_h != local_q) begin
                if ({1'b0, inj_h} < 4'(HART_COUNT)) begin
                  nr.kick_valid = 1'b1; nr.kick_hart = inj_h;
                end else nr.status_code = ST_PARAM;
              end else if (!lc[1]) nr.status_code = ST_STATE;
              else begin pend_q[s] <= 1'b1; go = 1'b1; end
            REQ_COMPLETE:
              if (lc != LC_RUNNING) nr.status_code = ST_STATE;
              else if (hof != local_q) nr.status_code = ST_PARAM;
              else begin
                lc_q[s] <= one_q[s] ? LC_REGISTERED : LC_ENABLED;
                go = 1'b1; res_on = 1'b1;
              end
            REQ_WRITE_ATTR:
              case (q_req_i.attr_index)
                ATTR_CONFIG:
                  if (q_req_i.write_value[63:1] != '0) nr.status_code = ST_PARAM;
                  else one_q[s] <= q_req_i.write_value[0];
                ATTR_PRIO:
                  if (lc[1]) nr.status_code = ST_STATE;
                  else prio_q[s] <= wh;
                ATTR_HART:
                  if (!glob) nr.status_code = ST_PARAM;
                  else if (lc[1]) nr.status_code = ST_STATE;
                  else if (wh >= 32'(HART_COUNT) || wh >= 32'd8 || !started_q[wh[2:0]])
                    nr.status_code = ST_PARAM;
                  else hart_q[s] <= wh[2:0];
                default: nr.status_code = ST_RANGE;
              endcase
            REQ_READ_ATTR:
              case (q_req_i.attr_index)
                ATTR_STATUS: nr.read_value = {60'd0, 1'b1, pend_q[s], lc};
                ATTR_PRIO:   nr.read_value = {32'd0, prio_q[s]};
                ATTR_CONFIG: nr.read_value = {63'd0, one_q[s]};
                ATTR_HART:   nr.read_value = {61'd0, hof};
                ATTR_PC:     nr.read_value = pc_mem[s];
                ATTR_ARG:    nr.read_value = arg_mem[s];
                default:     nr.status_code = ST_RANGE;
              endcase
            default: begin
              if (lc[1]) pend_q[s] <= 1'b1;
              else nr.status_code = ST_STATE;
              go = 1'b1;
            end
          endcase
          rsp_q <= nr;
          resume_on_q <= res_on;
          scan_q <= '0; best_v_q <= 1'b0; best_q <= '0;
          state_q <= go ? S_SCAN : S_OUT;
        end
        S_SCAN: begin
          rsp_t fin;
          fin = rsp_q;
          // one slot a cycle, strict less keeps the lowest index on ties
          if (scan_q == (SLOT_W+1)'(EVENT_SLOTS)) begin
            if (best_v_q && lc_q[best_q] != LC_RUNNING) begin
              lc_q[best_q] <= LC_RUNNING; pend_q[best_q] <= 1'b0;
              fin.run_valid = 1'b1; fin.run_event = 3'(best_q);
              fin.run_entry_pc = pc_mem[best_q];
              fin.run_entry_arg = arg_mem[best_q];
            end else if (resume_on_q) fin.resume = 1'b1;
            rsp_q <= fin;
            state_q <= S_OUT;
          end else begin
            if (cand && better) begin best_v_q <= 1'b1; best_q <= sc; end
            scan_q <= scan_q + 1'b1;
          end
        end
        S_OUT: if (m_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/core/software_event_dispatcher.sv @@
// ----------------------------------------------------------------------------
// software_event_dispatcher
// Per-hart software event controller with a decoded request queue.
// ----------------------------------------------------------------------------
// A request that starts no dispatch goes from idle straight to the output
// state; one that does first walks the slot table in the scan state, one slot
// per cycle. A two-beat queue in front takes requests while a result waits.
module software_event_dispatcher import sed_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [7:0]   cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // req_type[3:0], event_index[6:4], target_hart[9:7], attr_index[13:10],
  // write_value[77:14], second_value[141:78], zero fill
  input  logic [143:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status_code[1:0], run_valid[2], run_event[5:3], run_entry_pc[69:6],
  // run_entry_arg[133:70], resume[134], kick_valid[135], kick_hart[138:136],
  // read_value[202:139], zero fill
  output logic [207:0] m_axis_tdata
);
  logic qv, qpop;
  req_t qreq;
  rsp_t rsp;

  sed_front u_front (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid), .s_ready_o(s_axis_tready),
    .req_type_i(s_axis_tdata[3:0]), .event_index_i(s_axis_tdata[6:4]),
    .target_hart_i(s_axis_tdata[9:7]), .attr_index_i(s_axis_tdata[13:10]),
    .write_value_i(s_axis_tdata[77:14]), .second_value_i(s_axis_tdata[141:78]),
    .q_valid_o(qv), .q_pop_i(qpop), .q_req_o(qreq)
  );

  sed_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .q_valid_i(qv), .q_pop_o(qpop), .q_req_i(qreq),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_rsp_o(rsp)
  );

  assign m_axis_tdata = {5'd0, rsp.read_value, rsp.kick_hart, rsp.kick_valid,
                         rsp.resume, rsp.run_entry_arg, rsp.run_entry_pc,
                         rsp.run_event, rsp.run_valid, rsp.status_code};
endmodule

@@ rtl/core/sed_checker.sv @@
// ----------------------------------------------------------------------------
// sed_checks
// Port-level checks of the dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
module sed_checks (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [207:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed");
  a_run_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[133:3] == '0)
    else $error("run fields set without run_valid");
  a_kick_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[135] |-> m_axis_tdata[138:136] == '0)
    else $error("kick hart set without kick_valid");
  a_resume: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[134] |-> !m_axis_tdata[2] && !m_axis_tdata[135])
    else $error("resume with run or kick");
endmodule

bind software_event_dispatcher sed_checks u_sed_checks (.*);
